[design/msadp_pkg.sv]
// Shared types, codes and coefficient tables of the block ADPCM decoder.
package msadp_pkg;

	// Kind of work one accepted byte carries into the decode stage
	typedef enum logic [1:0] {
		ITEM_ERR,
		ITEM_HDR,
		ITEM_DATA
	} item_kind_t;

	// What a header byte writes
	typedef enum logic [1:0] {
		HOP_COEFF,
		HOP_LOW,
		HOP_WORD
	} hdr_op_t;

	// Header word groups, in stream order
	localparam logic [1:0] GRP_STEP    = 2'd0;
	localparam logic [1:0] GRP_SAMPLE1 = 2'd1;
	localparam logic [1:0] GRP_SAMPLE2 = 2'd2;

	// Configuration register indexes
	localparam logic REG_STEREO     = 1'b0;
	localparam logic REG_BLOCK_SIZE = 1'b1;

	localparam logic [15:0] BLOCK_SIZE_RST = 16'd256;
	localparam logic [4:0]  HDR_LEN_MONO   = 5'd7;
	localparam logic [4:0]  HDR_LEN_STEREO = 5'd14;
	localparam logic [2:0]  COEFF_MAX      = 3'd6;

	// One byte held between the front end and the decode stage
	typedef struct packed {
		item_kind_t kind;
		hdr_op_t    hop;
		logic       hlast;
		logic [1:0] grp;
		logic       ch;
		logic       blk_end;
		logic [7:0] data;
	} item_t;

	// Step adaptation factor per nibble code
	function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
		logic [9:0] f;
		case (nib)
			4'd4, 4'd12: f = 10'd307;
			4'd5, 4'd11: f = 10'd409;
			4'd6, 4'd10: f = 10'd512;
			4'd7, 4'd9:  f = 10'd614;
			4'd8:        f = 10'd768;
			default:     f = 10'd230;
		endcase
		return f;
	endfunction

	// First predictor coefficient
	function automatic logic signed [8:0] coeff1(input logic [2:0] idx);
		logic signed [8:0] c;
		case (idx)
			3'd0:    c = 9'sd64;
			3'd1:    c = 9'sd128;
			3'd2:    c = 9'sd0;
			3'd3:    c = 9'sd48;
			3'd4:    c = 9'sd60;
			3'd5:    c = 9'sd115;
			default: c = 9'sd98;
		endcase
		return c;
	endfunction

	// Second predictor coefficient
	function automatic logic signed [8:0] coeff2(input logic [2:0] idx);
		logic signed [8:0] c;
		case (idx)
			3'd0:    c = 9'sd0;
			3'd1:    c = -9'sd64;
			3'd2:    c = 9'sd0;
			3'd3:    c = 9'sd16;
			3'd4:    c = 9'sd0;
			3'd5:    c = -9'sd52;
			default: c = -9'sd58;
		endcase
		return c;
	endfunction

endpackage

[design/ms_adpcm_block_decoder_unit.sv]
// Block ADPCM decoder: top level with configuration registers.
// Bytes of the encoded stream enter one per beat on the input channel; decoded
// 16-bit samples leave one per beat on the output channel. A data byte is split
// into its nibbles, decoded in turn, since both pass through the single nibble
// decode unit and the second may depend on the first. The last header byte emits
// its stored samples, older ones first, and other header bytes emit none. The
// next byte is taken in the cycle its predecessor finishes, and a result waits
// in its own register, so a sustained data stream runs at one sample per cycle
// while the output is not stalled. Write stereo and the block length only while
// the decoder is idle.
module ms_adpcm_block_decoder_unit import msadp_pkg::*; #(
	parameter int STEP_WIDTH = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pcm_sample,
	output logic               channel,
	output logic               last,
	output logic               block_end,
	output logic               size_error
);

	logic        stereo_q;
	logic [15:0] blk_len_q;
	logic        item_valid;
	item_t       item;
	logic        item_done;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q  <= 1'b0;
			blk_len_q <= BLOCK_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEREO:     stereo_q <= cfg_data[0];
				REG_BLOCK_SIZE: blk_len_q <= cfg_data;
				default:        stereo_q <= stereo_q;
			endcase
		end
	end

	msadp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.stereo    (stereo_q),
		.blk_len   (blk_len_q),
		.item_done (item_done),
		.item_valid(item_valid),
		.item      (item)
	);

	msadp_core #(
		.STEP_WIDTH(STEP_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.stereo    (stereo_q),
		.item_valid(item_valid),
		.item      (item),
		.item_done (item_done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pcm_sample(pcm_sample),
		.channel   (channel),
		.last      (last),
		.block_end (block_end),
		.size_error(size_error)
	);

endmodule

[design/msadp_nibble.sv]
// Nibble decode: predictor, saturation and step adaptation for one sample.
module msadp_nibble import msadp_pkg::*; #(
	parameter int STEP_WIDTH = 24
) (
	input  logic signed [15:0]           sample1,
	input  logic signed [15:0]           sample2,
	input  logic signed [STEP_WIDTH-1:0] step,
	input  logic [2:0]                   tap_sel,
	input  logic [3:0]                   nib,
	output logic signed [15:0]           sample_new,
	output logic signed [STEP_WIDTH-1:0] step_new
);

	localparam int TW = STEP_WIDTH + 5;
	localparam int PW = STEP_WIDTH + 11;
	localparam logic signed [PW-1:0] STEP_MAX =
		$signed({{(PW-STEP_WIDTH+1){1'b0}}, {(STEP_WIDTH-1){1'b1}}});
	localparam logic signed [PW-1:0] STEP_MIN = PW'(16);
	localparam logic signed [TW-1:0] PCM_MAX = TW'(32767);
	localparam logic signed [TW-1:0] PCM_MIN = -TW'(32768);

	logic signed [24:0]           m1;
	logic signed [24:0]           m2;
	logic signed [25:0]           msum;
	logic signed [25:0]           mbias;
	logic signed [19:0]           pred;
	logic signed [3:0]            sn;
	logic signed [STEP_WIDTH+3:0] dq;
	logic signed [TW-1:0]         tot;
	logic signed [PW-1:0]         prod;
	logic signed [PW-1:0]         pbias;
	logic signed [PW-1:0]         quot;

	// Predict from the two previous samples, divide by 64 toward zero
	assign m1    = sample1 * coeff1(tap_sel);
	assign m2    = sample2 * coeff2(tap_sel);
	assign msum  = 26'(m1) + 26'(m2);
	assign mbias = msum[25] ? msum + 26'sd63 : msum;
	assign pred  = 20'(mbias >>> 6);

	// Add the scaled error term and clip to 16 bits
	assign sn  = $signed(nib);
	assign dq  = sn * step;
	assign tot = TW'(pred) + TW'(dq);

	always_comb begin
		if (tot > PCM_MAX) begin
			sample_new = 16'sh7fff;
		end else if (tot < PCM_MIN) begin
			sample_new = -16'sh8000;
		end else begin
			sample_new = 16'(tot);
		end
	end

	// Adapt the step: factor times step, divide by 256 toward zero, clamp
	assign prod  = $signed({1'b0, adapt_factor(nib)}) * step;
	assign pbias = prod[PW-1] ? prod + PW'(255) : prod;
	assign quot  = pbias >>> 8;

	always_comb begin
		if (quot < STEP_MIN) begin
			step_new = STEP_WIDTH'(STEP_MIN);
		end else if (quot > STEP_MAX) begin
			step_new = STEP_WIDTH'(STEP_MAX);
		end else begin
			step_new = STEP_WIDTH'(quot);
		end
	end

endmodule

[design/msadp_front.sv]
// Front end: block position counter, byte classification and input register.
module msadp_front import msadp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        stereo,
	input  logic [15:0] blk_len,
	input  logic        item_done,
	output logic        item_valid,
	output item_t       item
);

	logic        item_valid_q;
	item_t       item_q;
	item_t       item_d;
	logic [15:0] pos_q;
	logic [4:0]  hdr_len;
	logic [3:0]  chans;
	logic [3:0]  rel;
	logic [2:0]  field;
	logic        size_err;
	logic        end_blk;
	logic        accept;

	assign in_stall   = item_valid_q && !item_done;
	assign accept     = in_valid && !in_stall;
	assign item_valid = item_valid_q;
	assign item       = item_q;

	// Classify the byte by its position in the block
	assign hdr_len  = stereo ? HDR_LEN_STEREO : HDR_LEN_MONO;
	assign chans    = {2'b00, stereo, ~stereo};
	assign size_err = blk_len < 16'(hdr_len);
	assign end_blk  = ({1'b0, pos_q} + 17'd1) >= {1'b0, blk_len};
	assign rel      = pos_q[3:0] - chans;
	assign field    = rel[3:1];

	always_comb begin
		item_d         = '0;
		item_d.data    = data_byte;
		item_d.blk_end = end_blk;
		item_d.hlast   = pos_q == 16'(hdr_len - 5'd1);
		item_d.hop     = HOP_COEFF;
		item_d.ch      = pos_q[0];
		if (size_err) begin
			item_d.kind = ITEM_ERR;
		end else if (pos_q < 16'(hdr_len)) begin
			item_d.kind = ITEM_HDR;
			if (pos_q < 16'(chans)) begin
				item_d.hop = HOP_COEFF;
			end else if (!rel[0]) begin
				item_d.hop = HOP_LOW;
			end else begin
				item_d.hop = HOP_WORD;
				item_d.grp = stereo ? field[2:1] : field[1:0];
				item_d.ch  = stereo & field[0];
			end
		end else begin
			item_d.kind = ITEM_DATA;
		end
	end

	// Advance the position and hold the beat until the decode stage is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			item_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				item_valid_q <= 1'b1;
				if (size_err || end_blk) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 16'd1;
				end
			end else if (item_done) begin
				item_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_d;
		end
	end

endmodule

[design/msadp_core.sv]
// Decode stage: channel state, phase sequencer and result register.
module msadp_core import msadp_pkg::*; #(
	parameter int STEP_WIDTH = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               stereo,
	input  logic               item_valid,
	input  item_t              item,
	output logic               item_done,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pcm_sample,
	output logic               channel,
	output logic               last,
	output logic               block_end,
	output logic               size_error
);

	logic signed [15:0]           prev_q  [2];
	logic signed [15:0]           prev2_q [2];
	logic signed [STEP_WIDTH-1:0] stepsz_q [2];
	logic [2:0]                   coeff_q [2];
	logic [7:0]                   low_q;
	logic [1:0]                   phase_q;
	logic                         out_valid_q;

	logic [1:0]                   last_phase;
	logic                         emits;
	logic                         slot_free;
	logic                         fire;
	logic                         hdr_wr;
	logic                         dec_wr;
	logic                         dch;
	logic                         hch;
	logic [3:0]                   nib;
	logic signed [15:0]           word;
	logic signed [15:0]           nib_sample;
	logic signed [STEP_WIDTH-1:0] nib_step;
	logic signed [15:0]           res_pcm;
	logic                         res_ch;
	logic                         res_last;

	// Sequence the phases of the held beat
	always_comb begin
		case (item.kind)
			ITEM_HDR:  last_phase = item.hlast ? (stereo ? 2'd3 : 2'd1) : 2'd0;
			ITEM_DATA: last_phase = 2'd1;
			default:   last_phase = 2'd0;
		endcase
	end

	assign emits     = !(item.kind == ITEM_HDR && !item.hlast);
	assign slot_free = !out_valid_q || !out_stall;
	assign fire      = item_valid && (!emits || slot_free);
	assign item_done = fire && (phase_q == last_phase);
	assign hdr_wr    = fire && item.kind == ITEM_HDR && phase_q == 2'd0;
	assign dec_wr    = fire && item.kind == ITEM_DATA;

	// Decode upper nibble on channel 0, lower on channel 0 or 1
	assign dch  = phase_q[0] & stereo;
	assign nib  = phase_q[0] ? item.data[3:0] : item.data[7:4];
	assign word = $signed({item.data, low_q});
	assign hch  = stereo & phase_q[0];

	msadp_nibble #(
		.STEP_WIDTH(STEP_WIDTH)
	) u_nibble (
		.sample1   (prev_q[dch]),
		.sample2   (prev2_q[dch]),
		.step      (stepsz_q[dch]),
		.tap_sel   (coeff_q[dch]),
		.nib       (nib),
		.sample_new(nib_sample),
		.step_new  (nib_step)
	);

	// Select the result of this phase
	always_comb begin
		res_pcm  = '0;
		res_ch   = 1'b0;
		res_last = phase_q == last_phase;
		case (item.kind)
			ITEM_DATA: begin
				res_pcm = nib_sample;
				res_ch  = dch;
			end
			ITEM_HDR: begin
				res_ch = hch;
				if (!stereo && phase_q == 2'd0) begin
					res_pcm = word;
				end else if (stereo ? !phase_q[1] : phase_q == 2'd0) begin
					res_pcm = prev2_q[hch];
				end else begin
					res_pcm = prev_q[hch];
				end
			end
			default: begin
				res_pcm = '0;
			end
		endcase
	end

	// Update channel state from header writes and decoded nibbles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				prev_q[i]   <= '0;
				prev2_q[i]  <= '0;
				stepsz_q[i] <= '0;
				coeff_q[i]  <= '0;
			end
			low_q   <= '0;
			phase_q <= '0;
		end else begin
			if (fire) begin
				phase_q <= item_done ? 2'd0 : phase_q + 2'd1;
			end
			if (hdr_wr) begin
				case (item.hop)
					HOP_COEFF: begin
						coeff_q[item.ch] <= (item.data > 8'(COEFF_MAX)) ?
							COEFF_MAX : item.data[2:0];
					end
					HOP_LOW: begin
						low_q <= item.data;
					end
					default: begin
						case (item.grp)
							GRP_STEP:    stepsz_q[item.ch] <= STEP_WIDTH'(word);
							GRP_SAMPLE1: prev_q[item.ch] <= word;
							default:     prev2_q[item.ch] <= word;
						endcase
					end
				endcase
			end
			if (dec_wr) begin
				prev2_q[dch]  <= prev_q[dch];
				prev_q[dch]   <= nib_sample;
				stepsz_q[dch] <= nib_step;
			end
		end
	end

	// Result register: load on a produced result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emits) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emits) begin
			pcm_sample <= res_pcm;
			channel    <= res_ch;
			last       <= res_last;
			block_end  <= res_last && item.blk_end && item.kind != ITEM_ERR;
			size_error <= item.kind == ITEM_ERR;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[test/msadp_stream_checker.sv]
// Checker for the block ADPCM decoder: tracks the byte stream, predicts samples, compares.
`timescale 1ns / 100ps
module msadp_stream_checker import msadp_pkg::*; #(
	parameter int STEP_WIDTH = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] pcm_sample,
	input  logic               channel,
	input  logic               last,
	input  logic               block_end,
	input  logic               size_error,
	output int                 fails,
	output int                 outstanding,
	output int                 compared
);

	typedef struct {
		logic signed [15:0] pcm;
		logic               chan;
		logic               lst;
		logic               blk_end;
		logic               err;
	} sample_beat_t;

	localparam longint STEP_MAX = (longint'(1) << (STEP_WIDTH - 1)) - 1;

	// Decoder state as the stream so far leaves it
	logic                         stereo_r;
	logic [15:0]                  size_r;
	logic [15:0]                  pos_r;
	logic [2:0]                   coeff_r [2];
	logic signed [STEP_WIDTH-1:0] step_r [2];
	logic signed [15:0]           s1_r [2];
	logic signed [15:0]           s2_r [2];
	logic [7:0]                   low_r;

	sample_beat_t pending_samples [$];
	int           mismatch_total;
	int           checked_total;

	function automatic sample_beat_t make_beat(input logic signed [15:0] pcm, input logic ch);
		sample_beat_t bt;
		bt.pcm     = pcm;
		bt.chan    = ch;
		bt.lst     = 1'b0;
		bt.blk_end = 1'b0;
		bt.err     = 1'b0;
		return bt;
	endfunction

	// Predictor taps for a coefficient index
	function automatic void pred_taps(input logic [2:0] idx, output int c1, output int c2);
		case (idx)
			3'd0: begin c1 = 64;  c2 = 0;   end
			3'd1: begin c1 = 128; c2 = -64; end
			3'd2: begin c1 = 0;   c2 = 0;   end
			3'd3: begin c1 = 48;  c2 = 16;  end
			3'd4: begin c1 = 60;  c2 = 0;   end
			3'd5: begin c1 = 115; c2 = -52; end
			default: begin c1 = 98; c2 = -58; end
		endcase
	endfunction

	// Decode one nibble of a channel and adapt its step
	function automatic logic signed [15:0] advance_channel(input logic ch,
			input logic [3:0] nib);
		longint acc;
		longint nxt_step;
		int     c1;
		int     c2;
		int     code;
		int     mag;
		int     gain;
		pred_taps(coeff_r[ch], c1, c2);
		code = nib[3] ? int'(nib) - 16 : int'(nib);
		acc = (longint'(s1_r[ch]) * c1 + longint'(s2_r[ch]) * c2) / 64;
		acc = acc + longint'(code) * longint'(step_r[ch]);
		if (acc > 32767)
			acc = 32767;
		else if (acc < -32768)
			acc = -32768;
		s2_r[ch] = s1_r[ch];
		s1_r[ch] = acc[15:0];
		// Gain grows with the distance of the code from zero
		mag = nib[3] ? 16 - int'(nib) : int'(nib);
		gain = (mag <= 3) ? 230 : (mag == 4) ? 307 : (mag == 5) ? 409 :
			(mag == 6) ? 512 : (mag == 7) ? 614 : 768;
		nxt_step = longint'(gain) * longint'(step_r[ch]) / 256;
		if (nxt_step < 16)
			nxt_step = 16;
		if (nxt_step > STEP_MAX)
			nxt_step = STEP_MAX;
		step_r[ch] = nxt_step[STEP_WIDTH-1:0];
		return acc[15:0];
	endfunction

	// Work out the samples one byte causes and queue them
	task automatic queue_samples_for_byte(input logic [7:0] b);
		sample_beat_t       beats [4];
		int                 chans;
		int                 hdr;
		int                 pos;
		int                 n;
		int                 rel;
		int                 fld;
		int                 grp;
		int                 k;
		logic               ch;
		logic signed [15:0] word;
		bit                 endb;
		chans = stereo_r ? 2 : 1;
		hdr   = 7 * chans;
		pos   = int'(pos_r);
		n     = 0;
		// Undersized block: flag the byte and restart
		if (int'(size_r) < hdr) begin
			beats[0]     = make_beat(16'sd0, 1'b0);
			beats[0].lst = 1'b1;
			beats[0].err = 1'b1;
			pending_samples.push_back(beats[0]);
			pos_r = '0;
			return;
		end
		endb = (pos + 1 >= int'(size_r));
		if (pos < hdr) begin
			if (pos < chans) begin
				coeff_r[pos[0]] = (b > COEFF_MAX) ? COEFF_MAX : b[2:0];
			end else begin
				rel = pos - chans;
				if (!rel[0]) begin
					low_r = b;
				end else begin
					fld  = rel >> 1;
					grp  = fld / chans;
					ch   = (fld % chans) != 0;
					word = {b, low_r};
					if (grp == GRP_STEP)
						step_r[ch] = STEP_WIDTH'(word);
					else if (grp == GRP_SAMPLE1)
						s1_r[ch] = word;
					else
						s2_r[ch] = word;
				end
			end
			// Last header byte: older samples first
			if (pos == hdr - 1) begin
				beats[0] = make_beat(s2_r[0], 1'b0);
				if (stereo_r) begin
					beats[1] = make_beat(s2_r[1], 1'b1);
					beats[2] = make_beat(s1_r[0], 1'b0);
					beats[3] = make_beat(s1_r[1], 1'b1);
					n = 4;
				end else begin
					beats[1] = make_beat(s1_r[0], 1'b0);
					n = 2;
				end
			end
		end else begin
			beats[0] = make_beat(advance_channel(1'b0, b[7:4]), 1'b0);
			beats[1] = make_beat(advance_channel(stereo_r, b[3:0]), stereo_r);
			n = 2;
		end
		pos_r = endb ? '0 : 16'(pos + 1);
		if (n > 0) begin
			beats[n-1].lst     = 1'b1;
			beats[n-1].blk_end = endb;
		end
		for (k = 0; k < n; k++)
			pending_samples.push_back(beats[k]);
	endtask

	task automatic report_mismatch(input string what, input sample_beat_t want);
		mismatch_total++;
		if (mismatch_total <= 10)
			$display({"%0t: %s: expected pcm %0d ch %0d last %0d end %0d err %0d, ",
				"got pcm %0d ch %0d last %0d end %0d err %0d"},
				$time, what, want.pcm, want.chan, want.lst, want.blk_end, want.err,
				pcm_sample, channel, last, block_end, size_error);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		sample_beat_t want;
		int           c;
		if (!arst_n) begin
			stereo_r = 1'b0;
			size_r   = BLOCK_SIZE_RST;
			pos_r    = '0;
			low_r    = '0;
			for (c = 0; c < 2; c++) begin
				coeff_r[c] = '0;
				step_r[c]  = '0;
				s1_r[c]    = '0;
				s2_r[c]    = '0;
			end
			pending_samples.delete();
			mismatch_total = 0;
			checked_total  = 0;
			fails       <= 0;
			outstanding <= 0;
			compared    <= 0;
		end else begin
			// Apply register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STEREO:     stereo_r = cfg_data[0];
					REG_BLOCK_SIZE: size_r = cfg_data;
				endcase
			end
			// Compare each result beat with the oldest expectation
			if (out_valid && !out_stall) begin
				if (pending_samples.size() == 0) begin
					report_mismatch("result with nothing pending", make_beat(16'sd0, 1'b0));
				end else begin
					want = pending_samples.pop_front();
					checked_total++;
					if (pcm_sample !== want.pcm || channel !== want.chan || last !== want.lst ||
							block_end !== want.blk_end || size_error !== want.err)
						report_mismatch("sample mismatch", want);
				end
			end
			// Predict the samples of an accepted byte
			if (in_valid && !in_stall)
				queue_samples_for_byte(data_byte);
			outstanding <= pending_samples.size();
			fails       <= mismatch_total;
			compared    <= checked_total;
		end
	end

endmodule

[test/ms_adpcm_block_decoder_unit_tb.sv]
// Testbench top for the block ADPCM decoder: clock, reset, byte stream and verdict.
`timescale 1ns / 100ps
module ms_adpcm_block_decoder_unit_tb import msadp_pkg::*;;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_valid  = 1'b0;
	logic               cfg_index  = REG_STEREO;
	logic [15:0]        cfg_data   = '0;
	logic               in_valid   = 1'b0;
	logic [7:0]         data_byte  = '0;
	logic               out_stall  = 1'b0;
	logic               cfg_ready;
	logic               in_stall;
	logic               out_valid;
	logic signed [15:0] pcm_sample;
	logic               channel;
	logic               last;
	logic               block_end;
	logic               size_error;

	int fails;
	int outstanding;
	int compared;

	// Idle chances in percent, per byte on the input and per cycle on the output
	int gap_pct   = 0;
	int stall_pct = 0;
	int bytes_fed = 0;
	int setups    = 0;

	always #5 clk = ~clk;

	ms_adpcm_block_decoder_unit i_dut (.*);

	msadp_stream_checker i_checker (.*);

	// Stall the output in random bursts
	always begin
		@(posedge clk);
		if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 19)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	// Offer one byte, maybe after a gap, and hold it until taken
	task automatic feed_byte(input logic [7:0] b);
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_fed++;
	endtask

	// Send one whole block: header with random fields, then random data
	task automatic feed_block(input logic st, input int size);
		int          chans;
		int          g;
		int          c;
		int          k;
		logic [15:0] word;
		chans = st ? 2 : 1;
		for (c = 0; c < chans; c++)
			feed_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 255))
				: 8'($urandom_range(0, 6)));
		for (g = 0; g < 3; g++) begin
			for (c = 0; c < chans; c++) begin
				if (g == 0)
					word = ($urandom_range(0, 7) == 0) ? 16'($urandom)
						: 16'($urandom_range(16, 1200));
				else if ($urandom_range(0, 5) == 0)
					word = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				else
					word = 16'($urandom);
				feed_byte(word[7:0]);
				feed_byte(word[15:8]);
			end
		end
		for (k = 7 * chans; k < size; k++)
			feed_byte(8'($urandom));
	endtask

	// Drop valid and wait until every expected sample has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Write both registers once the decoder has gone quiet
	task automatic setup(input logic st, input logic [15:0] size);
		drain();
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_STEREO;
		cfg_data  <= {15'd0, st};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_BLOCK_SIZE;
		cfg_data  <= size;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		setups++;
	endtask

	initial begin : stim
		int   directed_bytes;
		int   hdr;
		int   size;
		int   cut;
		logic st;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: undersized blocks in mono and stereo
		gap_pct   = 15;
		stall_pct = 8;
		setup(1'b0, 16'd0);
		feed_byte(8'h00);
		feed_byte(8'hFF);
		setup(1'b1, 16'd13);
		feed_byte(8'hA5);
		// Largest block: clamped coefficient, negative step, extreme samples
		setup(1'b0, 16'hFFFF);
		feed_byte(8'hFF);
		feed_byte(8'h00);
		feed_byte(8'h80);
		feed_byte(8'hFF);
		feed_byte(8'h7F);
		feed_byte(8'h00);
		feed_byte(8'h80);
		feed_byte(8'h87);
		feed_byte(8'h08);
		// Shrink the block under the current position
		setup(1'b0, 16'd4);
		feed_byte(8'h7F);
		// Header-only block
		setup(1'b0, 16'd7);
		feed_block(1'b0, 7);
		directed_bytes = bytes_fed;

		// Random phases, mostly well-formed blocks
		while (bytes_fed - directed_bytes < 190) begin
			if (bytes_fed - directed_bytes >= 150) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: begin gap_pct = 0;  stall_pct = 0;  end
					1: begin gap_pct = 10; stall_pct = 5;  end
					default: begin gap_pct = 35; stall_pct = 20; end
				endcase
			end
			st  = 1'($urandom_range(0, 1));
			hdr = st ? 14 : 7;
			case ($urandom_range(0, 9))
				0: begin
					setup(st, 16'($urandom_range(0, hdr - 1)));
					repeat ($urandom_range(2, 5)) feed_byte(8'($urandom));
				end
				1: begin
					setup(st, 16'(hdr));
					repeat ($urandom_range(1, 2)) feed_block(st, hdr);
				end
				default: begin
					size = hdr + $urandom_range(1, 20);
					setup(st, 16'(size));
					repeat ($urandom_range(1, 3)) feed_block(st, size);
					// Now and then break off a block and realign the stream
					if ($urandom_range(0, 4) == 0) begin
						cut = $urandom_range(1, size - 1);
						repeat (cut) feed_byte(8'($urandom));
						setup(st, (cut >= hdr) ? 16'(hdr) : 16'd0);
						feed_byte(8'($urandom));
					end
				end
			endcase
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Fed %0d bytes over %0d register setups in mono and stereo,", bytes_fed, setups);
		$display("with undersized, header-only, shrunk and cut blocks; %0d samples compared.",
			compared);
		if (fails == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Give up if the stream hangs
	initial begin
		#5_000_000;
		$display("Timeout with %0d samples still expected", outstanding);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
